/* rtl/core/msr_pkg.sv */
package msr_pkg;

    localparam int SPD_W   = 15;
    localparam int RATE_W  = 17;
    localparam int US_W    = 20;
    localparam int DUTY_W  = 8;
    localparam int STEP_W  = 14;
    localparam int PCT_W   = 7;
    localparam int ADDR_W  = 4;
    localparam int DATA_W  = 32;

    localparam logic signed [SPD_W-1:0] SPEED_LIMIT = 15'sd10000;
    localparam logic signed [15:0]      SNAP_BAND   = 16'sd50;
    localparam logic [13:0]             MOVING_BAND = 14'd10;
    localparam logic [US_W-1:0]         TICK_MAX_US = 20'd100000;

    // 1e6 = 64 * 15625; floor(x / 15625) = (x * RECIP_15625) >> 42 for x < 2**28
    localparam logic [28:0] RECIP_15625 = 29'd281474977;
    localparam int          RECIP_15625_SH = 42;
    // floor(x / 100) = (x * RECIP_100) >> 21 for x < 2**14
    localparam logic [14:0] RECIP_100 = 15'd20972;
    localparam int          RECIP_100_SH = 21;

    localparam int DUTY_FULL = 255;
    localparam int PCT_DIV   = 100;

    typedef enum logic [2:0] {
        KIND_TICK   = 3'd0,
        KIND_TARGET = 3'd1,
        KIND_IMMED  = 3'd2,
        KIND_STOP   = 3'd3,
        KIND_BRAKE  = 3'd4
    } kind_t;

    typedef enum logic [1:0] {
        REG_ENABLE  = 2'd0,
        REG_REVERSE = 2'd1,
        REG_ACCEL   = 2'd2,
        REG_DECEL   = 2'd3
    } reg_idx_t;

    typedef logic [DUTY_W-1:0] duty_lut_t [2**PCT_W];

    function automatic duty_lut_t build_duty_lut();
        duty_lut_t lut;
        int v;
        for (int i = 0; i < 2**PCT_W; i++) begin
            v = (i * DUTY_FULL) / PCT_DIV;
            lut[i] = (v > DUTY_FULL) ? DUTY_W'(DUTY_FULL) : DUTY_W'(v);
        end
        return lut;
    endfunction

    localparam duty_lut_t DUTY_LUT = build_duty_lut();

endpackage

/* rtl/core/motor_speed_ramp_top.sv */
// Slew-rate limited motor speed with PWM duty and direction outputs. Takes one
// command beat per cycle unless backpressure holds the pipeline, and returns
// one result beat per command on the m_ side, through registered stages: the
// accel/decel step is formed by a rate-times-microseconds multiplier stage
// and a reciprocal divide-by-1e6 stage, then the speed state is updated in a
// single stage, and the duty lookup fills the output register.
// Backpressure stalls only the stages that are full. Configuration registers
// (enable, reverse_dir, accel_rate, decel_rate at 0x0, 0x4, 0x8, 0xC) should be
// written only while no commands are in flight.
module motor_speed_ramp_top (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                s_valid,
    output logic                                s_ready,
    input  logic [2:0]                          s_kind,
    input  logic signed [msr_pkg::SPD_W-1:0]    s_speed_value,
    input  logic [msr_pkg::US_W-1:0]            s_elapsed_us,
    output logic                                m_valid,
    input  logic                                m_ready,
    output logic [msr_pkg::DUTY_W-1:0]          m_pwm_duty,
    output logic                                m_direction,
    output logic                                m_moving,
    output logic signed [msr_pkg::SPD_W-1:0]    m_speed_now,
    input  logic                                psel,
    input  logic                                penable,
    input  logic                                pwrite,
    input  logic [msr_pkg::ADDR_W-1:0]          paddr,
    input  logic [msr_pkg::DATA_W-1:0]          pwdata,
    output logic [msr_pkg::DATA_W-1:0]          prdata,
    output logic                                pready
);
    import msr_pkg::*;

    // config
    logic              en_reg;
    logic              rev_reg;
    logic [RATE_W-1:0] accel_reg;
    logic [RATE_W-1:0] decel_reg;
    logic              cfg_wr;
    reg_idx_t          cfg_idx;

    assign pready  = 1'b1;
    assign cfg_wr  = psel & penable & pwrite;
    assign cfg_idx = reg_idx_t'(paddr[3:2]);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            en_reg    <= 1'b0;
            rev_reg   <= 1'b0;
            accel_reg <= 17'd5000;
            decel_reg <= 17'd5000;
        end else if (cfg_wr) begin
            case (cfg_idx)
                REG_ENABLE:  en_reg    <= pwdata[0];
                REG_REVERSE: rev_reg   <= pwdata[0];
                REG_ACCEL:   accel_reg <= pwdata[RATE_W-1:0];
                REG_DECEL:   decel_reg <= pwdata[RATE_W-1:0];
                default:     en_reg    <= en_reg;
            endcase
        end
    end

    always_comb begin
        case (cfg_idx)
            REG_ENABLE:  prdata = {{(DATA_W-1){1'b0}}, en_reg};
            REG_REVERSE: prdata = {{(DATA_W-1){1'b0}}, rev_reg};
            REG_ACCEL:   prdata = {{(DATA_W-RATE_W){1'b0}}, accel_reg};
            REG_DECEL:   prdata = {{(DATA_W-RATE_W){1'b0}}, decel_reg};
            default:     prdata = '0;
        endcase
    end

    // pipeline control
    logic v1_reg, v2_reg, v3_reg, v4_reg;
    logic ld1, ld2, ld3, ld4;

    assign ld4     = !v4_reg || m_ready;
    assign ld3     = !v3_reg || ld4;
    assign ld2     = !v2_reg || ld3;
    assign ld1     = !v1_reg || ld2;
    assign s_ready = ld1;
    assign m_valid = v4_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
        end else begin
            if (ld1) v1_reg <= s_valid;
            if (ld2) v2_reg <= v1_reg;
            if (ld3) v3_reg <= v2_reg;
            if (ld4) v4_reg <= v3_reg;
        end
    end

    // stage 1: clamp, tick check, rate * us
    logic [2:0]              kind1_reg;
    logic signed [SPD_W-1:0] req1_reg;
    logic                    tick_ok1_reg;
    logic [33:0]             prod_a1_reg;
    logic [33:0]             prod_d1_reg;
    logic signed [SPD_W-1:0] req_clamped;

    always_comb begin
        if (s_speed_value > SPEED_LIMIT) begin
            req_clamped = SPEED_LIMIT;
        end else if (s_speed_value < -SPEED_LIMIT) begin
            req_clamped = -SPEED_LIMIT;
        end else begin
            req_clamped = s_speed_value;
        end
    end

    always_ff @(posedge aclk) begin
        if (ld1 && s_valid) begin
            kind1_reg    <= s_kind;
            req1_reg     <= req_clamped;
            tick_ok1_reg <= (s_elapsed_us != '0) && (s_elapsed_us <= TICK_MAX_US);
            prod_a1_reg  <= 34'(accel_reg) * 34'(s_elapsed_us[16:0]);
            prod_d1_reg  <= 34'(decel_reg) * 34'(s_elapsed_us[16:0]);
        end
    end

    // stage 2: divide by 1e6 through reciprocal
    logic [2:0]              kind2_reg;
    logic signed [SPD_W-1:0] req2_reg;
    logic                    tick_ok2_reg;
    logic [STEP_W-1:0]       step_a2_reg;
    logic [STEP_W-1:0]       step_d2_reg;
    logic [56:0]             qa_prod;
    logic [56:0]             qd_prod;

    assign qa_prod = 57'(prod_a1_reg[33:6]) * 57'(RECIP_15625);
    assign qd_prod = 57'(prod_d1_reg[33:6]) * 57'(RECIP_15625);

    always_ff @(posedge aclk) begin
        if (ld2 && v1_reg) begin
            kind2_reg    <= kind1_reg;
            req2_reg     <= req1_reg;
            tick_ok2_reg <= tick_ok1_reg;
            step_a2_reg  <= qa_prod[RECIP_15625_SH+STEP_W-1:RECIP_15625_SH];
            step_d2_reg  <= qd_prod[RECIP_15625_SH+STEP_W-1:RECIP_15625_SH];
        end
    end

    // stage 3: speed state update
    logic signed [SPD_W-1:0] cur_reg, cur_next;
    logic signed [SPD_W-1:0] tgt_reg, tgt_next;
    logic                    brk_reg, brk_next;
    logic signed [SPD_W-1:0] spd3_reg;
    logic                    drive3_reg;
    logic signed [15:0]      cur_x, tgt_x, diff, up_sum, dn_sum;
    logic signed [SPD_W-1:0] tick_spd;

    assign cur_x  = {cur_reg[SPD_W-1], cur_reg};
    assign tgt_x  = {tgt_reg[SPD_W-1], tgt_reg};
    assign diff   = tgt_x - cur_x;
    assign up_sum = cur_x + $signed({2'b00, step_a2_reg});
    assign dn_sum = cur_x - $signed({2'b00, step_d2_reg});

    always_comb begin
        if ((diff < SNAP_BAND) && (diff > -SNAP_BAND)) begin
            tick_spd = tgt_reg;
        end else if (diff > 16'sd0) begin
            tick_spd = (up_sum > tgt_x) ? tgt_reg : up_sum[SPD_W-1:0];
        end else begin
            tick_spd = (dn_sum < tgt_x) ? tgt_reg : dn_sum[SPD_W-1:0];
        end
    end

    always_comb begin
        cur_next = cur_reg;
        tgt_next = tgt_reg;
        brk_next = brk_reg;
        case (kind_t'(kind2_reg))
            KIND_TICK: begin
                if (en_reg && tick_ok2_reg) begin
                    cur_next = tick_spd;
                    brk_next = 1'b0;
                end
            end
            KIND_TARGET: begin
                tgt_next = req2_reg;
            end
            KIND_IMMED: begin
                tgt_next = req2_reg;
                cur_next = req2_reg;
                brk_next = 1'b0;
            end
            KIND_STOP: begin
                tgt_next = '0;
            end
            KIND_BRAKE: begin
                tgt_next = '0;
                cur_next = '0;
                brk_next = 1'b1;
            end
            default: begin
                cur_next = cur_reg;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cur_reg <= '0;
            tgt_reg <= '0;
            brk_reg <= 1'b0;
        end else if (ld3 && v2_reg) begin
            cur_reg <= cur_next;
            tgt_reg <= tgt_next;
            brk_reg <= brk_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (ld3 && v2_reg) begin
            spd3_reg   <= cur_next;
            drive3_reg <= en_reg & ~brk_next;
        end
    end

    // stage 4: outputs
    logic [SPD_W-1:0]  abs_full;
    logic [13:0]       mag4;
    logic [28:0]       pct_prod;
    logic [PCT_W-1:0]  pct;
    logic [DUTY_W-1:0] duty_reg;
    logic              dir_reg;
    logic              moving_reg;
    logic signed [SPD_W-1:0] speed_reg;

    assign abs_full = spd3_reg[SPD_W-1] ? SPD_W'(-spd3_reg) : SPD_W'(spd3_reg);
    assign mag4     = abs_full[13:0];
    assign pct_prod = 29'(mag4) * 29'(RECIP_100);
    assign pct      = pct_prod[RECIP_100_SH+PCT_W-1:RECIP_100_SH];

    always_ff @(posedge aclk) begin
        if (ld4 && v3_reg) begin
            duty_reg   <= drive3_reg ? DUTY_LUT[pct] : '0;
            dir_reg    <= drive3_reg & (~spd3_reg[SPD_W-1] ^ rev_reg);
            moving_reg <= mag4 > MOVING_BAND;
            speed_reg  <= spd3_reg;
        end
    end

    assign m_pwm_duty  = duty_reg;
    assign m_direction = dir_reg;
    assign m_moving    = moving_reg;
    assign m_speed_now = speed_reg;

endmodule

/* rtl/core/msr_checker.sv */
module msr_checker (
    input logic                                aclk,
    input logic                                aresetn,
    input logic                                m_valid,
    input logic                                m_ready,
    input logic [msr_pkg::DUTY_W-1:0]          m_pwm_duty,
    input logic                                m_moving,
    input logic signed [msr_pkg::SPD_W-1:0]    m_speed_now
);
    import msr_pkg::*;

    // stalled result beat holds
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_speed_now) && $stable(m_pwm_duty))
        else $error("result beat changed while stalled");

    a_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_speed_now <= SPEED_LIMIT) && (m_speed_now >= -SPEED_LIMIT))
        else $error("speed out of range");

    a_duty_moving: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && (m_pwm_duty != '0) |-> m_moving)
        else $error("nonzero duty while not moving");

    a_still: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_moving |-> (m_speed_now <= 15'sd10) && (m_speed_now >= -15'sd10))
        else $error("moving flag low with speed beyond band");

endmodule

bind motor_speed_ramp_top msr_checker u_msr_checker (.*);

/* verif/tb.sv */
`timescale 1ns / 100ps

module tb;
    import msr_pkg::*;

    localparam longint US_PER_SEC = 1000000;

    typedef struct {
        logic [DUTY_W-1:0]       duty;
        logic                    dir;
        logic                    moving;
        logic signed [SPD_W-1:0] speed;
    } speed_report_t;

    logic                    aclk;
    logic                    aresetn;
    logic                    s_valid;
    logic                    s_ready;
    logic [2:0]              s_kind;
    logic signed [SPD_W-1:0] s_speed_value;
    logic [US_W-1:0]         s_elapsed_us;
    logic                    m_valid;
    logic                    m_ready;
    logic [DUTY_W-1:0]       m_pwm_duty;
    logic                    m_direction;
    logic                    m_moving;
    logic signed [SPD_W-1:0] m_speed_now;
    logic                    psel;
    logic                    penable;
    logic                    pwrite;
    logic [ADDR_W-1:0]       paddr;
    logic [DATA_W-1:0]       pwdata;
    logic [DATA_W-1:0]       prdata;
    logic                    pready;

    // shadow of the block's registers and ramp state
    bit          en_q;
    bit          rev_q;
    int unsigned accel_q;
    int unsigned decel_q;
    int          cur_spd;
    int          tgt_spd;
    bit          brk_q;

    speed_report_t speed_reports[$];
    int            mismatch_count;
    bit            no_idle;
    int            rx_hold;

    motor_speed_ramp_top uut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_kind        (s_kind),
        .s_speed_value (s_speed_value),
        .s_elapsed_us  (s_elapsed_us),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_pwm_duty    (m_pwm_duty),
        .m_direction   (m_direction),
        .m_moving      (m_moving),
        .m_speed_now   (m_speed_now),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready)
    );

    initial aclk = 1'b0;
    always #1 aclk = ~aclk;

    function automatic int slew_step(int unsigned rate, logic [US_W-1:0] us);
        longint p;
        p = longint'(rate) * longint'(us) / US_PER_SEC;
        if (p > 2 * int'(SPEED_LIMIT))
            p = 2 * int'(SPEED_LIMIT);
        return int'(p);
    endfunction

    function automatic speed_report_t advance_ramp(logic [2:0] k, logic signed [SPD_W-1:0] v,
                                                   logic [US_W-1:0] us);
        speed_report_t r;
        int req;
        int diff;
        int nxt;
        int mag;
        req = int'(v);
        if (req > int'(SPEED_LIMIT))
            req = int'(SPEED_LIMIT);
        else if (req < -int'(SPEED_LIMIT))
            req = -int'(SPEED_LIMIT);
        case (k)
            KIND_TICK: begin
                if (en_q && us != '0 && us <= TICK_MAX_US) begin
                    diff = tgt_spd - cur_spd;
                    mag = (diff < 0) ? -diff : diff;
                    if (mag < int'(SNAP_BAND)) begin
                        cur_spd = tgt_spd;
                    end else if (diff > 0) begin
                        nxt = cur_spd + slew_step(accel_q, us);
                        cur_spd = (nxt > tgt_spd) ? tgt_spd : nxt;
                    end else begin
                        nxt = cur_spd - slew_step(decel_q, us);
                        cur_spd = (nxt < tgt_spd) ? tgt_spd : nxt;
                    end
                    brk_q = 1'b0;
                end
            end
            KIND_TARGET: tgt_spd = req;
            KIND_IMMED: begin
                tgt_spd = req;
                cur_spd = req;
                brk_q = 1'b0;
            end
            KIND_STOP: tgt_spd = 0;
            KIND_BRAKE: begin
                tgt_spd = 0;
                cur_spd = 0;
                brk_q = 1'b1;
            end
            default: ;
        endcase
        mag = (cur_spd < 0) ? -cur_spd : cur_spd;
        r.duty = '0;
        r.dir = 1'b0;
        if (en_q && !brk_q) begin
            r.duty = DUTY_W'((mag / 100) * DUTY_FULL / PCT_DIV);
            r.dir = (cur_spd >= 0) ^ rev_q;
        end
        r.moving = (mag > int'(MOVING_BAND));
        r.speed = SPD_W'(cur_spd);
        return r;
    endfunction

    // called at a falling edge, returns at a falling edge with valid still high
    task automatic send_cmd(input logic [2:0] k, input logic [SPD_W-1:0] v,
                            input logic [US_W-1:0] us);
        int gap;
        gap = no_idle ? 0 : $urandom_range(0, 5);
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_valid       <= 1'b1;
        s_kind        <= k;
        s_speed_value <= v;
        s_elapsed_us  <= us;
        do @(posedge aclk); while (!s_ready);
        speed_reports.push_back(advance_ramp(k, v, us));
        @(negedge aclk);
    endtask

    task automatic drain_results();
        s_valid <= 1'b0;
        while (speed_reports.size() != 0) @(posedge aclk);
        repeat (6) @(posedge aclk);
        @(negedge aclk);
    endtask

    task automatic apb_write(input reg_idx_t idx, input int unsigned value);
        psel    <= 1'b1;
        pwrite  <= 1'b1;
        penable <= 1'b0;
        paddr   <= {idx, 2'b00};
        pwdata  <= value;
        @(negedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        case (idx)
            REG_ENABLE:  en_q = value[0];
            REG_REVERSE: rev_q = value[0];
            REG_ACCEL:   accel_q = value & 32'h1FFFF;
            REG_DECEL:   decel_q = value & 32'h1FFFF;
            default: ;
        endcase
        @(negedge aclk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(negedge aclk);
    endtask

    always @(negedge aclk) begin
        if (rx_hold > 0) begin
            m_ready <= 1'b0;
            rx_hold <= rx_hold - 1;
        end else begin
            m_ready <= 1'b1;
        end
    end

    always @(posedge aclk) begin
        speed_report_t want;
        if (aresetn && m_valid && m_ready) begin
            if (speed_reports.size() == 0) begin
                mismatch_count++;
                if (mismatch_count <= 10)
                    $display("unexpected beat: duty %0d dir %0b moving %0b speed %0d",
                             m_pwm_duty, m_direction, m_moving, m_speed_now);
            end else begin
                want = speed_reports.pop_front();
                if (m_pwm_duty !== want.duty || m_direction !== want.dir ||
                    m_moving !== want.moving || m_speed_now !== want.speed) begin
                    mismatch_count++;
                    if (mismatch_count <= 10)
                        $display("mismatch: exp %0d %0b %0b %0d, got %0d %0b %0b %0d",
                                 want.duty, want.dir, want.moving, want.speed,
                                 m_pwm_duty, m_direction, m_moving, m_speed_now);
                end
            end
            rx_hold <= no_idle ? 0 : $urandom_range(0, 5);
        end
    end

    task automatic test_disabled_outputs();
        send_cmd(KIND_TICK, '0, 20'd1000);
        send_cmd(KIND_IMMED, 15'sd5000, '0);
        send_cmd(3'd7, '0, '0);
        send_cmd(KIND_TARGET, -15'sd3000, '0);
        send_cmd(KIND_TICK, '0, 20'd100000);
        send_cmd(KIND_BRAKE, '0, '0);
        drain_results();
    endtask

    task automatic test_limits_and_snap();
        apb_write(REG_ENABLE, 1);
        send_cmd(KIND_IMMED, 15'sd10000, '0);
        send_cmd(KIND_IMMED, 15'h3FFF, '0);
        send_cmd(KIND_IMMED, 15'h4000, '0);
        send_cmd(KIND_TICK, '0, 20'd100000);
        send_cmd(KIND_IMMED, '0, '0);
        send_cmd(KIND_TARGET, 15'sd49, '0);
        send_cmd(KIND_TICK, '0, 20'd1);
        send_cmd(KIND_TARGET, 15'sd99, '0);
        send_cmd(KIND_TICK, '0, 20'd1);
        send_cmd(KIND_TICK, '0, 20'd100000);
        send_cmd(KIND_TARGET, 15'sd10000, '0);
        send_cmd(KIND_TICK, '0, '0);
        send_cmd(KIND_TICK, '0, 20'd100001);
        send_cmd(KIND_TICK, '0, 20'hFFFFF);
        send_cmd(KIND_TICK, '0, 20'd100000);
        send_cmd(KIND_STOP, '0, '0);
        send_cmd(KIND_TICK, '0, 20'd100000);
        send_cmd(KIND_BRAKE, '0, '0);
        send_cmd(KIND_TICK, '0, 20'd1);
        send_cmd(3'd5, 15'sd1234, 20'd500);
        send_cmd(3'd6, '0, '0);
        drain_results();
    endtask

    task automatic test_rates_and_reverse();
        apb_write(REG_REVERSE, 1);
        apb_write(REG_ACCEL, 131071);
        apb_write(REG_DECEL, 0);
        send_cmd(KIND_IMMED, -15'sd10000, '0);
        send_cmd(KIND_TARGET, 15'sd10000, '0);
        send_cmd(KIND_TICK, '0, 20'd100000);
        send_cmd(KIND_TARGET, -15'sd10000, '0);
        send_cmd(KIND_TICK, '0, 20'd100000);
        send_cmd(KIND_IMMED, -15'sd20, '0);
        send_cmd(KIND_IMMED, 15'sd11, '0);
        drain_results();
        apb_write(REG_ACCEL, 0);
        apb_write(REG_DECEL, 100000);
        send_cmd(KIND_TARGET, 15'sd8000, '0);
        send_cmd(KIND_TICK, '0, 20'd100000);
        send_cmd(KIND_STOP, '0, '0);
        send_cmd(KIND_TICK, '0, 20'd100000);
        drain_results();
    endtask

    task automatic test_random_ramps();
        int unsigned rate_pick[6];
        int sent;
        int n;
        rate_pick = '{0, 1, 5000, 100000, 131071, 0};
        for (int p = 0; p < 6; p++) begin
            drain_results();
            apb_write(REG_ENABLE, (p == 2) ? 0 : 1);
            apb_write(REG_REVERSE, $urandom_range(0, 1));
            apb_write(REG_ACCEL, (p == 5) ? $urandom_range(0, 100000) : rate_pick[p]);
            apb_write(REG_DECEL, (p == 5) ? $urandom_range(0, 100000) : rate_pick[5 - p]);
            sent = 0;
            while (sent < 85) begin
                no_idle = ($urandom_range(0, 3) == 0);
                if ($urandom_range(0, 9) == 0)
                    drain_results();
                if ($urandom_range(0, 3) != 0) begin
                    send_cmd($urandom_range(0, 1) ? KIND_TARGET : KIND_IMMED,
                             SPD_W'($urandom_range(0, 20000) - 10000), US_W'($urandom));
                    n = $urandom_range(3, 8);
                    for (int i = 0; i < n; i++)
                        send_cmd($urandom_range(0, 9) ? KIND_TICK : KIND_STOP,
                                 SPD_W'($urandom),
                                 US_W'($urandom_range(0, 1) ? $urandom_range(1, 100000)
                                                            : $urandom_range(1, 2000)));
                    sent += n + 1;
                end else begin
                    n = $urandom_range(1, 4);
                    for (int i = 0; i < n; i++)
                        send_cmd(3'($urandom_range(0, 7)), SPD_W'($urandom),
                                 US_W'($urandom));
                    sent += n;
                end
            end
        end
        no_idle = 1'b0;
        drain_results();
    endtask

    initial begin
        aresetn       = 1'b0;
        s_valid       = 1'b0;
        s_kind        = '0;
        s_speed_value = '0;
        s_elapsed_us  = '0;
        m_ready       = 1'b0;
        psel          = 1'b0;
        penable       = 1'b0;
        pwrite        = 1'b0;
        paddr         = '0;
        pwdata        = '0;
        rx_hold       = 0;
        no_idle       = 1'b0;
        mismatch_count = 0;
        en_q    = 1'b0;
        rev_q   = 1'b0;
        accel_q = 5000;
        decel_q = 5000;
        cur_spd = 0;
        tgt_spd = 0;
        brk_q   = 1'b0;
        repeat (8) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        test_disabled_outputs();
        test_limits_and_snap();
        test_rates_and_reverse();
        test_random_ramps();

        if (mismatch_count == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

    initial begin
        #1000000;
        $display("Simulation FAILED");
        $finish;
    end

endmodule
